### hdl/skrt_pkg.sv
// Package: types and constants for the sorted keyed record table.
`timescale 1ns / 1ps
`default_nettype none
package skrt_pkg;
    localparam int TableDepth = 64;
    localparam int CntW = $clog2(TableDepth + 1);

    typedef enum logic [2:0] {
        MODE_UPSERT = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_LOOKUP = 3'd2,
        MODE_CLEAR  = 3'd3,
        MODE_COMMIT = 3'd4,
        MODE_RESET  = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_FOUND     = 3'd5,
        ST_DONE      = 3'd6
    } t_status;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] entity_id;
        logic [63:0] record_payload;
        logic [31:0] tick;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] found_payload;
        logic [6:0]  entry_total;
        logic [31:0] stored_tick;
        logic [31:0] frame_counter;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;
endpackage
`default_nettype wire

### hdl/sorted_keyed_record_table.sv
// Top level: sorted keyed record table.
// The result strobe is registered from busy and rises in the cycle after busy.
// Each command runs capture/compare, then shift/execute; a new command is not taken while busy.
// busy is high during the execute cycle only.
// Synchronous active-low reset empties the table and zeroes tick and frame count.
// The receiver cannot stall; each result is marked by a strobe that is high for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module sorted_keyed_record_table
    import skrt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_in  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out      o_result
);
    t_cmd cmd;

    skrt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start),
        .busy(busy), .o_cmd(cmd)
    );

    skrt_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_cmd(cmd),
        .o_done(o_strobe), .o_res(o_result)
    );
endmodule
`default_nettype wire

### hdl/skrt_ctrl.sv
// Controller: sequences capture, compare and execute of one command.
`timescale 1ns / 1ps
`default_nettype none
module skrt_ctrl
    import skrt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    output t_cmd      o_cmd
);
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start) n_state = S_EXEC;
            S_EXEC: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign busy          = (r_state == S_EXEC);
    assign o_cmd.capture = (r_state == S_IDLE) && start;
    assign o_cmd.execute = (r_state == S_EXEC);
endmodule
`default_nettype wire

### hdl/skrt_dp.sv
// Datapath: row of cells holding the sorted records, with compare and shift.
`timescale 1ns / 1ps
`default_nettype none
module skrt_dp
    import skrt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_item,
    input  wire t_cmd i_cmd,
    output logic      o_done,
    output t_out      o_res
);
    logic [15:0]     r_ids [TableDepth];
    logic [63:0]     r_pay [TableDepth];
    logic [CntW-1:0] r_used;
    logic [31:0]     r_tick, r_frames;
    t_in             r_item;
    logic            r_done;
    t_out            r_res;

    // per-cell compare, registered after capture
    logic [TableDepth-1:0] r_lt, r_eq;
    logic [TableDepth-1:0] c_lt, c_eq;

    always_comb begin
        for (int i = 0; i < TableDepth; i++) begin
            c_lt[i] = (CntW'(i) < r_used) && (r_ids[i] < i_item.entity_id);
            c_eq[i] = (CntW'(i) < r_used) && (r_ids[i] == i_item.entity_id);
        end
    end

    logic            hit, full;
    logic [63:0]     hit_pay;
    logic [CntW-1:0] n_used;
    always_comb begin
        hit     = |r_eq;
        full    = (r_used >= CntW'(TableDepth));
        hit_pay = '0;
        // r_eq is one-hot or zero
        for (int i = 0; i < TableDepth; i++)
            hit_pay = hit_pay | ({64{r_eq[i]}} & r_pay[i]);
    end

    always_comb begin
        n_used = r_used;
        case (r_item.mode)
            MODE_UPSERT: if (!hit && !full) n_used = r_used + 1'b1;
            MODE_REMOVE: if (hit) n_used = r_used - 1'b1;
            MODE_CLEAR, MODE_RESET: n_used = '0;
            default: n_used = r_used;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
            r_lt   <= c_lt;
            r_eq   <= c_eq;
        end
        if (i_cmd.execute) begin
            for (int i = 0; i < TableDepth; i++) begin
                if (r_item.mode == MODE_UPSERT) begin
                    if (r_eq[i]) begin
                        r_pay[i] <= r_item.record_payload;
                    end else if (!hit && !full && !r_lt[i] && (CntW'(i) <= r_used)) begin
                        if (i == 0 || r_lt[(i == 0) ? 0 : i-1]) begin
                            r_ids[i] <= r_item.entity_id;
                            r_pay[i] <= r_item.record_payload;
                        end else begin
                            r_ids[i] <= r_ids[(i == 0) ? 0 : i-1];
                            r_pay[i] <= r_pay[(i == 0) ? 0 : i-1];
                        end
                    end
                end else if (r_item.mode == MODE_REMOVE && hit && i < TableDepth-1) begin
                    if (!r_lt[i]) begin
                        r_ids[i] <= r_ids[(i == TableDepth-1) ? i : i+1];
                        r_pay[i] <= r_pay[(i == TableDepth-1) ? i : i+1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_tick   <= '0;
            r_frames <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.execute;
            if (i_cmd.execute) begin
                r_used <= n_used;
                if (r_item.mode == MODE_COMMIT) begin
                    r_tick   <= r_item.tick;
                    r_frames <= r_frames + 1'b1;
                end else if (r_item.mode == MODE_RESET) begin
                    r_tick   <= '0;
                    r_frames <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_res.found_payload <= '0;
            case (r_item.mode)
                MODE_UPSERT:
                    r_res.status <= hit ? ST_UPDATED : (full ? ST_FULL : ST_INSERTED);
                MODE_REMOVE: r_res.status <= hit ? ST_REMOVED : ST_NOT_FOUND;
                MODE_LOOKUP: begin
                    r_res.status <= hit ? ST_FOUND : ST_NOT_FOUND;
                    if (hit) r_res.found_payload <= hit_pay;
                end
                default: r_res.status <= ST_DONE;
            endcase
            r_res.entry_total   <= 7'(n_used);
            r_res.stored_tick   <= (r_item.mode == MODE_COMMIT) ? r_item.tick :
                                   (r_item.mode == MODE_RESET) ? 32'd0 : r_tick;
            r_res.frame_counter <= (r_item.mode == MODE_COMMIT) ? r_frames + 1'b1 :
                                   (r_item.mode == MODE_RESET) ? 32'd0 : r_frames;
        end
    end

    assign o_done    = r_done;
    assign o_res     = r_res;
endmodule
`default_nettype wire

### hdl/skrt_checker.sv
// Checker: port-level properties of the record table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module skrt_checker
    import skrt_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_strobe,
    input wire t_out o_result
);
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy missing");
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_strobe) else $error("strobe missing");
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.entry_total <= 7'(TableDepth))) else $error("count");
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_FOUND) |-> (o_result.found_payload == 64'd0))
        else $error("payload");
endmodule

bind sorted_keyed_record_table skrt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_strobe(o_strobe), .o_result(o_result)
);
`default_nettype wire

### tb/sv/tb_sorted_keyed_record_table.sv
// Testbench: sorted keyed record table checked against a behavioural table model.
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_keyed_record_table;
    import skrt_pkg::*;

    class table_scoreboard;
        logic [15:0] ids[TableDepth];
        logic [63:0] pays[TableDepth];
        int unsigned used;
        logic [31:0] ftick;
        logic [31:0] fcount;
        t_out pending[$];
        int errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            used = 0;
            ftick = '0;
            fcount = '0;
        endfunction

        function void note_transfer(t_in it);
            t_out r;
            int unsigned pos;
            bit hit;
            r = '0;
            r.status = ST_DONE;
            pos = 0;
            while (pos < used && ids[pos] < it.entity_id) pos++;
            hit = (pos < used) && (ids[pos] == it.entity_id);
            case (it.mode)
                MODE_UPSERT: begin
                    if (hit) begin
                        pays[pos] = it.record_payload;
                        r.status = ST_UPDATED;
                    end else if (used >= TableDepth) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int k = used; k > pos; k--) begin
                            ids[k] = ids[k-1];
                            pays[k] = pays[k-1];
                        end
                        ids[pos] = it.entity_id;
                        pays[pos] = it.record_payload;
                        used++;
                        r.status = ST_INSERTED;
                    end
                end
                MODE_REMOVE: begin
                    if (hit) begin
                        for (int k = pos; k + 1 < used; k++) begin
                            ids[k] = ids[k+1];
                            pays[k] = pays[k+1];
                        end
                        used--;
                        r.status = ST_REMOVED;
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
                MODE_LOOKUP: begin
                    if (hit) begin
                        r.found_payload = pays[pos];
                        r.status = ST_FOUND;
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
                MODE_CLEAR: used = 0;
                MODE_COMMIT: begin
                    ftick = it.tick;
                    fcount = fcount + 1;
                end
                MODE_RESET: wipe();
                default: ;
            endcase
            r.entry_total = used[6:0];
            r.stored_tick = ftick;
            r.frame_counter = fcount;
            pending.push_back(r);
        endfunction

        function void check_result(t_out act);
            t_out exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, act);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (act.status !== exp.status)
                $display("%0t: status exp %0d act %0d", $time, exp.status, act.status);
            if (act.found_payload !== exp.found_payload)
                $display("%0t: found_payload exp %h act %h", $time,
                         exp.found_payload, act.found_payload);
            if (act.entry_total !== exp.entry_total)
                $display("%0t: entry_total exp %0d act %0d", $time,
                         exp.entry_total, act.entry_total);
            if (act.stored_tick !== exp.stored_tick)
                $display("%0t: stored_tick exp %h act %h", $time,
                         exp.stored_tick, act.stored_tick);
            if (act.frame_counter !== exp.frame_counter)
                $display("%0t: frame_counter exp %0d act %0d", $time,
                         exp.frame_counter, act.frame_counter);
            if (act !== exp) errors++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_in  i_item = '0;
    logic busy;
    logic o_strobe;
    t_out o_result;

    table_scoreboard sb = new();
    int idle_pct = 0;

    sorted_keyed_record_table u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item),
        .busy(busy), .o_strobe(o_strobe), .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_result);
    end

    // drive one command; start stays high across back-to-back transfers
    task automatic send_cmd(t_mode m, logic [15:0] id, logic [63:0] pay, logic [31:0] tk);
        t_in it;
        it.mode = m;
        it.entity_id = id;
        it.record_payload = pay;
        it.tick = tk;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_transfer(it);
    endtask

    task automatic go_idle();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        go_idle();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_id(int span);
        if (sb.used > 0 && $urandom_range(1))
            return sb.ids[$urandom_range(sb.used - 1)];
        if (span == 0) return 16'($urandom);
        return 16'($urandom_range(span));
    endfunction

    task automatic random_cmd(int span);
        int r;
        t_mode m;
        logic [2:0] raw;
        r = $urandom_range(99);
        if (r < 45) m = MODE_UPSERT;
        else if (r < 65) m = MODE_REMOVE;
        else if (r < 87) m = MODE_LOOKUP;
        else if (r < 92) m = MODE_COMMIT;
        else if (r < 95) m = MODE_CLEAR;
        else if (r < 96) m = MODE_RESET;
        else begin
            raw = 3'($urandom_range(6, 7));
            m = t_mode'(raw);
        end
        send_cmd(m, pick_id(span), {$urandom, $urandom}, $urandom);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, every mode, full table
        send_cmd(MODE_LOOKUP, 16'h0000, '0, '0);
        send_cmd(MODE_REMOVE, 16'hFFFF, '0, '0);
        send_cmd(MODE_UPSERT, 16'hFFFF, '1, '1);
        send_cmd(MODE_UPSERT, 16'h0000, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
        send_cmd(MODE_UPSERT, 16'h8000, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        send_cmd(MODE_UPSERT, 16'h0000, '1, '0);
        send_cmd(MODE_LOOKUP, 16'h0000, '0, '0);
        send_cmd(MODE_LOOKUP, 16'hFFFF, '0, '0);
        send_cmd(MODE_LOOKUP, 16'h7FFF, '0, '0);
        send_cmd(MODE_REMOVE, 16'h8000, '0, '0);
        send_cmd(MODE_REMOVE, 16'h8000, '0, '0);
        send_cmd(MODE_COMMIT, '0, '0, 32'hFFFF_FFFF);
        send_cmd(MODE_COMMIT, '1, '1, 32'h0000_0000);
        send_cmd(t_mode'(3'd6), '1, '1, '1);
        send_cmd(t_mode'(3'd7), '0, '0, '1);
        send_cmd(MODE_CLEAR, '0, '0, '0);
        send_cmd(MODE_LOOKUP, 16'hFFFF, '0, '0);
        send_cmd(MODE_RESET, '0, '0, '0);
        for (int i = 0; i < TableDepth; i++)
            send_cmd(MODE_UPSERT, 16'(TableDepth - 1 - i) * 16'd1000, {$urandom, $urandom}, '0);
        send_cmd(MODE_UPSERT, 16'd1, '1, '0);
        send_cmd(MODE_UPSERT, 16'd0, '0, '0);
        send_cmd(MODE_REMOVE, 16'd0, '0, '0);
        send_cmd(MODE_LOOKUP, 16'd63000, '0, '0);
        drain();

        // random phases with different sender idling and key spans
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 75;
                2: idle_pct = 0;
                default: idle_pct = 35;
            endcase
            for (int n = 0; n < 166; n++) begin
                if ($urandom_range(29) == 0) begin
                    go_idle();
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end
                random_cmd(ph < 4 ? 127 : 0);
            end
            if (ph == 3) drain();
        end
        // frame replacement sequences: clear then sorted upserts
        idle_pct = 10;
        for (int f = 0; f < 6; f++) begin
            send_cmd(MODE_CLEAR, '0, '0, '0);
            for (int i = 0; i < 20; i++)
                send_cmd(MODE_UPSERT, 16'(i * 3 + f), {$urandom, $urandom}, '0);
            send_cmd(MODE_COMMIT, '0, '0, $urandom);
        end
        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
